[sv/pit_pkg.sv]
// shared types and constants for the point-in-triangle test pipeline
// no dependencies; imported by every pit_* module and the top level

package pit_pkg;

   // the only vertex count that describes a triangle
   localparam logic [3:0] VALID_COUNT = 4'd3;

   // per-item flags that travel alongside the arithmetic
   typedef struct packed {
      logic bad_count;   // vertex count was not three
      logic box_ab;      // point within bounding box of segment a-b
      logic box_bc;      // point within bounding box of segment b-c
      logic box_ca;      // point within bounding box of segment c-a
   } flags_type;

endpackage

[sv/pit_diff.sv]
// stage 1: edge and point difference vectors, bounding box checks, count check
// depends on pit_pkg

module pit_diff import pit_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] ax,
   input  logic signed [COORD_WIDTH-1:0] ay,
   input  logic signed [COORD_WIDTH-1:0] bx,
   input  logic signed [COORD_WIDTH-1:0] by_coord,
   input  logic signed [COORD_WIDTH-1:0] cx,
   input  logic signed [COORD_WIDTH-1:0] cy,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic [3:0]                    vertex_count,
   output logic signed [COORD_WIDTH:0]   e0x_ff,
   output logic signed [COORD_WIDTH:0]   e0y_ff,
   output logic signed [COORD_WIDTH:0]   e1x_ff,
   output logic signed [COORD_WIDTH:0]   e1y_ff,
   output logic signed [COORD_WIDTH:0]   wx_ff,
   output logic signed [COORD_WIDTH:0]   wy_ff,
   output logic signed [COORD_WIDTH:0]   bcx_ff,
   output logic signed [COORD_WIDTH:0]   bcy_ff,
   output logic signed [COORD_WIDTH:0]   bpx_ff,
   output logic signed [COORD_WIDTH:0]   bpy_ff,
   output logic signed [COORD_WIDTH:0]   cax_ff,
   output logic signed [COORD_WIDTH:0]   cay_ff,
   output logic signed [COORD_WIDTH:0]   cpx_ff,
   output logic signed [COORD_WIDTH:0]   cpy_ff,
   output flags_type                     flags_ff
);

   localparam int DW = COORD_WIDTH + 1;

   flags_type flags_in;

   // closed interval test, endpoints in either order
   function automatic logic in_span(input logic signed [COORD_WIDTH-1:0] s,
                                    input logic signed [COORD_WIDTH-1:0] t,
                                    input logic signed [COORD_WIDTH-1:0] q);
      return ((q >= s) && (q <= t)) || ((q >= t) && (q <= s));
   endfunction

   always_comb begin
      flags_in.bad_count = (vertex_count != VALID_COUNT);
      flags_in.box_ab    = in_span(ax, bx, px) && in_span(ay, by_coord, py);
      flags_in.box_bc    = in_span(bx, cx, px) && in_span(by_coord, cy, py);
      flags_in.box_ca    = in_span(cx, ax, px) && in_span(cy, ay, py);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0x_ff   <= DW'(cx) - DW'(ax);
         e0y_ff   <= DW'(cy) - DW'(ay);
         e1x_ff   <= DW'(bx) - DW'(ax);
         e1y_ff   <= DW'(by_coord) - DW'(ay);
         wx_ff    <= DW'(px) - DW'(ax);
         wy_ff    <= DW'(py) - DW'(ay);
         bcx_ff   <= DW'(cx) - DW'(bx);
         bcy_ff   <= DW'(cy) - DW'(by_coord);
         bpx_ff   <= DW'(px) - DW'(bx);
         bpy_ff   <= DW'(py) - DW'(by_coord);
         cax_ff   <= DW'(ax) - DW'(cx);
         cay_ff   <= DW'(ay) - DW'(cy);
         cpx_ff   <= DW'(px) - DW'(cx);
         cpy_ff   <= DW'(py) - DW'(cy);
         flags_ff <= flags_in;
      end
   end

endmodule

[sv/pit_mult.sv]
// stage 2: the ten partial products of the five cross products
// depends on pit_pkg

module pit_mult import pit_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [COORD_WIDTH:0]       e0x,
   input  logic signed [COORD_WIDTH:0]       e0y,
   input  logic signed [COORD_WIDTH:0]       e1x,
   input  logic signed [COORD_WIDTH:0]       e1y,
   input  logic signed [COORD_WIDTH:0]       wx,
   input  logic signed [COORD_WIDTH:0]       wy,
   input  logic signed [COORD_WIDTH:0]       bcx,
   input  logic signed [COORD_WIDTH:0]       bcy,
   input  logic signed [COORD_WIDTH:0]       bpx,
   input  logic signed [COORD_WIDTH:0]       bpy,
   input  logic signed [COORD_WIDTH:0]       cax,
   input  logic signed [COORD_WIDTH:0]       cay,
   input  logic signed [COORD_WIDTH:0]       cpx,
   input  logic signed [COORD_WIDTH:0]       cpy,
   input  flags_type                         flags,
   output logic signed [2*COORD_WIDTH+1:0]   d_p0_ff,
   output logic signed [2*COORD_WIDTH+1:0]   d_p1_ff,
   output logic signed [2*COORD_WIDTH+1:0]   u_p0_ff,
   output logic signed [2*COORD_WIDTH+1:0]   u_p1_ff,
   output logic signed [2*COORD_WIDTH+1:0]   v_p0_ff,
   output logic signed [2*COORD_WIDTH+1:0]   v_p1_ff,
   output logic signed [2*COORD_WIDTH+1:0]   bc_p0_ff,
   output logic signed [2*COORD_WIDTH+1:0]   bc_p1_ff,
   output logic signed [2*COORD_WIDTH+1:0]   ca_p0_ff,
   output logic signed [2*COORD_WIDTH+1:0]   ca_p1_ff,
   output flags_type                         flags_ff
);

   localparam int PW = 2*COORD_WIDTH + 2;

   always_ff @(posedge clock) begin
      if (en) begin
         d_p0_ff  <= PW'(e0x) * PW'(e1y);
         d_p1_ff  <= PW'(e0y) * PW'(e1x);
         u_p0_ff  <= PW'(wx) * PW'(e1y);
         u_p1_ff  <= PW'(wy) * PW'(e1x);
         v_p0_ff  <= PW'(e0x) * PW'(wy);
         v_p1_ff  <= PW'(e0y) * PW'(wx);
         bc_p0_ff <= PW'(bcx) * PW'(bpy);
         bc_p1_ff <= PW'(bcy) * PW'(bpx);
         ca_p0_ff <= PW'(cax) * PW'(cpy);
         ca_p1_ff <= PW'(cay) * PW'(cpx);
         flags_ff <= flags;
      end
   end

endmodule

[sv/pit_cross.sv]
// stage 3: cross products from partial products (determinant, u, v, edge tests)
// depends on pit_pkg

module pit_cross import pit_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [2*COORD_WIDTH+1:0]   d_p0,
   input  logic signed [2*COORD_WIDTH+1:0]   d_p1,
   input  logic signed [2*COORD_WIDTH+1:0]   u_p0,
   input  logic signed [2*COORD_WIDTH+1:0]   u_p1,
   input  logic signed [2*COORD_WIDTH+1:0]   v_p0,
   input  logic signed [2*COORD_WIDTH+1:0]   v_p1,
   input  logic signed [2*COORD_WIDTH+1:0]   bc_p0,
   input  logic signed [2*COORD_WIDTH+1:0]   bc_p1,
   input  logic signed [2*COORD_WIDTH+1:0]   ca_p0,
   input  logic signed [2*COORD_WIDTH+1:0]   ca_p1,
   input  flags_type                         flags,
   output logic signed [2*COORD_WIDTH+2:0]   det_ff,
   output logic signed [2*COORD_WIDTH+2:0]   u_num_ff,
   output logic signed [2*COORD_WIDTH+2:0]   v_num_ff,
   output logic signed [2*COORD_WIDTH+2:0]   cross_bc_ff,
   output logic signed [2*COORD_WIDTH+2:0]   cross_ca_ff,
   output flags_type                         flags_ff
);

   localparam int CW = 2*COORD_WIDTH + 3;

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff      <= CW'(d_p0) - CW'(d_p1);
         u_num_ff    <= CW'(u_p0) - CW'(u_p1);
         v_num_ff    <= CW'(v_p0) - CW'(v_p1);
         cross_bc_ff <= CW'(bc_p0) - CW'(bc_p1);
         cross_ca_ff <= CW'(ca_p0) - CW'(ca_p1);
         flags_ff    <= flags;
      end
   end

endmodule

[sv/pit_decide.sv]
// stage 4: sign-oriented barycentric compare, degenerate edge test, result register
// depends on pit_pkg

module pit_decide import pit_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [2*COORD_WIDTH+2:0]   det,
   input  logic signed [2*COORD_WIDTH+2:0]   u_num,
   input  logic signed [2*COORD_WIDTH+2:0]   v_num,
   input  logic signed [2*COORD_WIDTH+2:0]   cross_bc,
   input  logic signed [2*COORD_WIDTH+2:0]   cross_ca,
   input  flags_type                         flags,
   output logic                              inside_res_ff,
   output logic                              degenerate_ff,
   output logic                              bad_count_ff
);

   localparam int SW = 2*COORD_WIDTH + 4;

   logic signed [SW-1:0] uv_sum;
   logic signed [SW-1:0] det_ext;
   logic                 det_zero;
   logic                 on_edge;
   logic                 in_tri;
   logic                 inside_res_in;
   logic                 degenerate_in;

   always_comb begin
      uv_sum   = SW'(u_num) + SW'(v_num);
      det_ext  = SW'(det);
      det_zero = (det == '0);
      // segment a-b uses cross(e1, w), which is the negated u numerator
      on_edge  = (flags.box_ab && (u_num == '0)) ||
                 (flags.box_bc && (cross_bc == '0)) ||
                 (flags.box_ca && (cross_ca == '0));
      if (det > 0) begin
         in_tri = (u_num >= 0) && (v_num >= 0) && (uv_sum <= det_ext);
      end else begin
         in_tri = (u_num <= 0) && (v_num <= 0) && (uv_sum >= det_ext);
      end
      if (flags.bad_count) begin
         inside_res_in = 1'b0;
         degenerate_in = 1'b0;
      end else if (det_zero) begin
         inside_res_in = on_edge;
         degenerate_in = 1'b1;
      end else begin
         inside_res_in = in_tri;
         degenerate_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_res_ff <= inside_res_in;
         degenerate_ff <= degenerate_in;
         bad_count_ff  <= flags.bad_count;
      end
   end

endmodule

[sv/point_in_triangle_test.sv]
// point-in-triangle test, four-stage pipeline. one transfer in per clock while
// req_ready is high, one result out per item, results in order. each item goes
// through the four register stages (differences, multipliers, cross products,
// compare); sustained rate is one item per cycle while rsp_ready is held. a
// stage holds its item while the one after it is full and stalled; empty stages
// collapse, so up to four items can be in flight and req_ready stays high while
// any stage is free. the point counts as inside when it lies inside or on the
// triangle; with a zero determinant each edge is tested as a segment and
// degenerate is set; a vertex count other than three returns bad_count with
// inside_res and degenerate low. depends on pit_pkg and the pit_diff, pit_mult,
// pit_cross and pit_decide stage modules

module point_in_triangle_test import pit_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel: triangle, point and vertex count
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [COORD_WIDTH-1:0] req_cx,
   input  logic signed [COORD_WIDTH-1:0] req_cy,
   input  logic signed [COORD_WIDTH-1:0] req_px,
   input  logic signed [COORD_WIDTH-1:0] req_py,
   input  logic [3:0]                    req_vertex_count,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_inside_res,
   output logic                          rsp_degenerate,
   output logic                          rsp_bad_count
);

   localparam int DW     = COORD_WIDTH + 1;       // difference width
   localparam int PW     = 2*COORD_WIDTH + 2;     // partial product width
   localparam int CW     = 2*COORD_WIDTH + 3;     // cross product width
   localparam int STAGES = 4;

   // stage valid bits, index 0 is the difference stage, STAGES-1 the result
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_en;

   // stage 1 outputs
   logic signed [DW-1:0] e0x, e0y, e1x, e1y, wx, wy;
   logic signed [DW-1:0] bcx, bcy, bpx, bpy, cax, cay, cpx, cpy;
   flags_type            flags_s1;

   // stage 2 outputs
   logic signed [PW-1:0] d_p0, d_p1, u_p0, u_p1, v_p0, v_p1;
   logic signed [PW-1:0] bc_p0, bc_p1, ca_p0, ca_p1;
   flags_type            flags_s2;

   // stage 3 outputs
   logic signed [CW-1:0] det, u_num, v_num, cross_bc, cross_ca;
   flags_type            flags_s3;

   // a stage loads when it is empty or its item moves on this cycle;
   // the last stage moves on when the result transfer completes
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES-2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // edge vectors, point offsets, bounding boxes and count check
   pit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
      .clock        (clock),
      .en           (stage_en[0]),
      .ax           (req_ax),
      .ay           (req_ay),
      .bx           (req_bx),
      .by_coord     (req_by_coord),
      .cx           (req_cx),
      .cy           (req_cy),
      .px           (req_px),
      .py           (req_py),
      .vertex_count (req_vertex_count),
      .e0x_ff       (e0x),
      .e0y_ff       (e0y),
      .e1x_ff       (e1x),
      .e1y_ff       (e1y),
      .wx_ff        (wx),
      .wy_ff        (wy),
      .bcx_ff       (bcx),
      .bcy_ff       (bcy),
      .bpx_ff       (bpx),
      .bpy_ff       (bpy),
      .cax_ff       (cax),
      .cay_ff       (cay),
      .cpx_ff       (cpx),
      .cpy_ff       (cpy),
      .flags_ff     (flags_s1)
   );

   // ten multipliers, registered
   pit_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock    (clock),
      .en       (stage_en[1]),
      .e0x      (e0x),
      .e0y      (e0y),
      .e1x      (e1x),
      .e1y      (e1y),
      .wx       (wx),
      .wy       (wy),
      .bcx      (bcx),
      .bcy      (bcy),
      .bpx      (bpx),
      .bpy      (bpy),
      .cax      (cax),
      .cay      (cay),
      .cpx      (cpx),
      .cpy      (cpy),
      .flags    (flags_s1),
      .d_p0_ff  (d_p0),
      .d_p1_ff  (d_p1),
      .u_p0_ff  (u_p0),
      .u_p1_ff  (u_p1),
      .v_p0_ff  (v_p0),
      .v_p1_ff  (v_p1),
      .bc_p0_ff (bc_p0),
      .bc_p1_ff (bc_p1),
      .ca_p0_ff (ca_p0),
      .ca_p1_ff (ca_p1),
      .flags_ff (flags_s2)
   );

   // determinant, u and v numerators, and edge cross products
   pit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock       (clock),
      .en          (stage_en[2]),
      .d_p0        (d_p0),
      .d_p1        (d_p1),
      .u_p0        (u_p0),
      .u_p1        (u_p1),
      .v_p0        (v_p0),
      .v_p1        (v_p1),
      .bc_p0       (bc_p0),
      .bc_p1       (bc_p1),
      .ca_p0       (ca_p0),
      .ca_p1       (ca_p1),
      .flags       (flags_s2),
      .det_ff      (det),
      .u_num_ff    (u_num),
      .v_num_ff    (v_num),
      .cross_bc_ff (cross_bc),
      .cross_ca_ff (cross_ca),
      .flags_ff    (flags_s3)
   );

   // final compare into the result register
   pit_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
      .clock         (clock),
      .en            (stage_en[3]),
      .det           (det),
      .u_num         (u_num),
      .v_num         (v_num),
      .cross_bc      (cross_bc),
      .cross_ca      (cross_ca),
      .flags         (flags_s3),
      .inside_res_ff (rsp_inside_res),
      .degenerate_ff (rsp_degenerate),
      .bad_count_ff  (rsp_bad_count)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for point_in_triangle_test: directed and random triangles
// checked against an integer barycentric predictor; depends on pit_pkg and the rtl

module tb_top;
   import pit_pkg::*;

   localparam int COORD_WIDTH  = 16;
   localparam int COORD_MAX    = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN    = -(1 << (COORD_WIDTH - 1));
   // generous bound: every item pays a full sender gap, a full receiver stall and latency
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int TAIL_CYCLES    = 8;

   // one triangle query as it crosses the input channel
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic [3:0]                    vertex_count;
   } tri_query;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
      logic bad_count;
   } tri_verdict;

   // expected verdict kept with its query so a mismatch can say what was asked
   typedef struct packed {
      tri_query   query;
      tri_verdict verdict;
   } verdict_entry;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic signed [COORD_WIDTH-1:0] req_ax           = '0;
   logic signed [COORD_WIDTH-1:0] req_ay           = '0;
   logic signed [COORD_WIDTH-1:0] req_bx           = '0;
   logic signed [COORD_WIDTH-1:0] req_by_coord     = '0;
   logic signed [COORD_WIDTH-1:0] req_cx           = '0;
   logic signed [COORD_WIDTH-1:0] req_cy           = '0;
   logic signed [COORD_WIDTH-1:0] req_px           = '0;
   logic signed [COORD_WIDTH-1:0] req_py           = '0;
   logic [3:0]                    req_vertex_count = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic                          rsp_inside_res;
   logic                          rsp_degenerate;
   logic                          rsp_bad_count;

   // verdicts still owed by the block, oldest first
   verdict_entry pending_verdicts[$];
   int           error_count = 0;

   // idling controls: src_gaps for the sender, sink_stalls and hold_cycles for the receiver
   bit src_gaps    = 1'b0;
   bit sink_stalls = 1'b0;
   int hold_cycles = 0;

   point_in_triangle_test #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ax           (req_ax),
      .req_ay           (req_ay),
      .req_bx           (req_bx),
      .req_by_coord     (req_by_coord),
      .req_cx           (req_cx),
      .req_cy           (req_cy),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_vertex_count (req_vertex_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_bad_count    (rsp_bad_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor: exact integer barycentric test, no division
   // ------------------------------------------------------------------

   function automatic longint cross_z(longint x0, longint y0, longint x1, longint y1);
      return x0 * y1 - y0 * x1;
   endfunction

   function automatic bit between(longint s, longint t, longint q);
      return (s < t) ? (q >= s && q <= t) : (q >= t && q <= s);
   endfunction

   // q on the closed segment s-t: collinear and inside the bounding box
   function automatic bit on_edge_segment(longint sx, longint sy, longint tx, longint ty,
                                          longint qx, longint qy);
      if (cross_z(tx - sx, ty - sy, qx - sx, qy - sy) != 0)
         return 1'b0;
      return between(sx, tx, qx) && between(sy, ty, qy);
   endfunction

   function automatic tri_verdict predict_containment(tri_query q);
      longint     xa, ya, xb, yb, xc, yc, xp, yp;
      longint     det, u_num, v_num;
      tri_verdict v;
      v = '0;
      if (q.vertex_count != VALID_COUNT) begin
         v.bad_count = 1'b1;
         return v;
      end
      xa = longint'(q.ax);  ya = longint'(q.ay);
      xb = longint'(q.bx);  yb = longint'(q.by_coord);
      xc = longint'(q.cx);  yc = longint'(q.cy);
      xp = longint'(q.px);  yp = longint'(q.py);
      det = cross_z(xc - xa, yc - ya, xb - xa, yb - ya);
      if (det == 0) begin
         // flat triangle: the point has to sit on an edge of the triangle
         v.degenerate = 1'b1;
         v.inside_res = on_edge_segment(xa, ya, xb, yb, xp, yp) ||
                        on_edge_segment(xb, yb, xc, yc, xp, yp) ||
                        on_edge_segment(xc, yc, xa, ya, xp, yp);
         return v;
      end
      u_num = cross_z(xp - xa, yp - ya, xb - xa, yb - ya);
      v_num = cross_z(xc - xa, yc - ya, xp - xa, yp - ya);
      // orientation of the winding decides which way the bounds point
      if (det > 0)
         v.inside_res = u_num >= 0 && v_num >= 0 && u_num + v_num <= det;
      else
         v.inside_res = u_num <= 0 && v_num <= 0 && u_num + v_num >= det;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // query construction
   // ------------------------------------------------------------------

   function automatic tri_query make_query(int ax, int ay, int bx, int by, int cx, int cy,
                                           int px, int py, int count);
      tri_query q;
      q.ax = COORD_WIDTH'(ax);  q.ay = COORD_WIDTH'(ay);
      q.bx = COORD_WIDTH'(bx);  q.by_coord = COORD_WIDTH'(by);
      q.cx = COORD_WIDTH'(cx);  q.cy = COORD_WIDTH'(cy);
      q.px = COORD_WIDTH'(px);  q.py = COORD_WIDTH'(py);
      q.vertex_count = 4'(count);
      return q;
   endfunction

   function automatic int clamp_coord(int v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < COORD_MIN)
         return COORD_MIN;
      return v;
   endfunction

   function automatic int rand_span(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int rand_full();
      return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
   endfunction

   // mix of shapes: mostly small triangles and collinear sets so that inside,
   // edge and degenerate outcomes all turn up, plus full-range noise and bad counts
   function automatic tri_query random_query();
      int       shape, span, ox, oy, dx, dy, k, m, j, w1, w2, w3;
      int       ax, ay, bx, by, cx, cy, px, py;
      tri_query q;
      shape = $urandom_range(0, 99);
      ax = rand_full();  ay = rand_full();
      bx = rand_full();  by = rand_full();
      cx = rand_full();  cy = rand_full();
      px = rand_full();  py = rand_full();
      if (shape < 15) begin
         // collinear vertices, sometimes all on one spot; point on the line or one off it
         ax = rand_span(16000);  ay = rand_span(16000);
         dx = ($urandom_range(0, 3) == 0) ? 0 : rand_span(100);
         dy = ($urandom_range(0, 3) == 0) ? 0 : rand_span(100);
         k = rand_span(100);  m = rand_span(100);  j = rand_span(110);
         bx = ax + k * dx;  by = ay + k * dy;
         cx = ax + m * dx;  cy = ay + m * dy;
         px = ax + j * dx + (($urandom_range(0, 2) == 0) ? rand_span(1) : 0);
         py = ay + j * dy + (($urandom_range(0, 2) == 0) ? rand_span(1) : 0);
      end else if (shape < 60) begin
         // small to wide triangles around a random center
         case ($urandom_range(0, 3))
            0:       span = 2;
            1:       span = 40;
            2:       span = 2000;
            default: span = 20000;
         endcase
         ox = rand_full();  oy = rand_full();
         ax = clamp_coord(ox + rand_span(span));  ay = clamp_coord(oy + rand_span(span));
         bx = clamp_coord(ox + rand_span(span));  by = clamp_coord(oy + rand_span(span));
         cx = clamp_coord(ox + rand_span(span));  cy = clamp_coord(oy + rand_span(span));
         if ($urandom_range(0, 1) == 0) begin
            // weighted vertex average, truncated toward zero, lands inside or close to the triangle
            w1 = $urandom_range(0, 8);  w2 = $urandom_range(0, 8);  w3 = $urandom_range(0, 8);
            if (w1 + w2 + w3 == 0)
               w1 = 1;
            px = (w1 * ax + w2 * bx + w3 * cx) / (w1 + w2 + w3);
            py = (w1 * ay + w2 * by + w3 * cy) / (w1 + w2 + w3);
         end else begin
            px = clamp_coord(ox + rand_span(span));
            py = clamp_coord(oy + rand_span(span));
         end
      end
      q = make_query(ax, ay, bx, by, cx, cy, px, py, VALID_COUNT);
      if (shape >= 90) begin
         // any count but the valid one
         q.vertex_count = 4'($urandom_range(0, 14));
         if (q.vertex_count >= VALID_COUNT)
            q.vertex_count = q.vertex_count + 4'd1;
      end
      return q;
   endfunction

   // ------------------------------------------------------------------
   // sender: one transfer per call, optional idle burst in front
   // ------------------------------------------------------------------

   task automatic send_query(tri_query q);
      @(negedge clock);
      if (src_gaps && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ax           = q.ax;
      req_ay           = q.ay;
      req_bx           = q.bx;
      req_by_coord     = q.by_coord;
      req_cx           = q.cx;
      req_cy           = q.cy;
      req_px           = q.px;
      req_py           = q.py;
      req_vertex_count = q.vertex_count;
      req_valid        = 1'b1;
      // valid stays up until the transfer; the caller drops it when it stops sending
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every owed verdict
   task automatic wait_verdicts_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // receiver: random stall bursts, or one long hold-off counted here
   // ------------------------------------------------------------------

   initial begin
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_ready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // scoreboard: predict on each input transfer, check each result transfer
   // ------------------------------------------------------------------

   task automatic report_field(string field, logic want, logic got, tri_query q);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %0b actual %0b (a=%0d,%0d b=%0d,%0d c=%0d,%0d p=%0d,%0d n=%0d)",
                  $time, field, want, got, q.ax, q.ay, q.bx, q.by_coord, q.cx, q.cy,
                  q.px, q.py, q.vertex_count);
      end
   endtask

   always @(posedge clock) begin : verdict_check
      tri_query     seen;
      verdict_entry oldest;
      if (!reset && req_valid && req_ready) begin
         seen = '{req_ax, req_ay, req_bx, req_by_coord, req_cx, req_cy, req_px, req_py,
                  req_vertex_count};
         pending_verdicts.push_back('{seen, predict_containment(seen)});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing outstanding, expected none actual %0b%0b%0b",
                     $time, rsp_inside_res, rsp_degenerate, rsp_bad_count);
         end else begin
            oldest = pending_verdicts.pop_front();
            report_field("inside_res", oldest.verdict.inside_res, rsp_inside_res, oldest.query);
            report_field("degenerate", oldest.verdict.degenerate, rsp_degenerate, oldest.query);
            report_field("bad_count", oldest.verdict.bad_count, rsp_bad_count, oldest.query);
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // hand-picked shapes: both windings, edges and vertices, the coordinate
   // extremes, flat and single-point triangles, and invalid vertex counts
   task automatic test_directed_cases();
      send_query(make_query(0, 0, 10, 0, 0, 10, 2, 2, VALID_COUNT));      // clearly inside
      send_query(make_query(0, 0, 10, 0, 0, 10, 10, 10, VALID_COUNT));    // outside
      send_query(make_query(0, 0, 10, 0, 0, 10, 5, 5, VALID_COUNT));      // on hypotenuse
      send_query(make_query(0, 0, 10, 0, 0, 10, 0, 0, VALID_COUNT));      // on a vertex
      send_query(make_query(0, 0, 10, 0, 0, 10, -1, 0, VALID_COUNT));     // just past a vertex
      send_query(make_query(0, 0, 0, 10, 10, 0, 2, 2, VALID_COUNT));      // other winding
      send_query(make_query(0, 0, 0, 10, 10, 0, 11, 0, VALID_COUNT));
      // largest triangle the coordinates allow
      send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            -1, -1, VALID_COUNT));
      send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            0, 0, VALID_COUNT));
      send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            COORD_MAX, COORD_MAX, VALID_COUNT));
      send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            COORD_MIN, COORD_MIN, VALID_COUNT));
      // flat triangles: point on, beyond and beside the line
      send_query(make_query(0, 0, 4, 4, 8, 8, 2, 2, VALID_COUNT));
      send_query(make_query(0, 0, 4, 4, 8, 8, 9, 9, VALID_COUNT));
      send_query(make_query(0, 0, 4, 4, 8, 8, 1, 2, VALID_COUNT));
      send_query(make_query(COORD_MIN, COORD_MIN, 0, 0, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, VALID_COUNT));
      // all three vertices on one spot
      send_query(make_query(5, -5, 5, -5, 5, -5, 5, -5, VALID_COUNT));
      send_query(make_query(5, -5, 5, -5, 5, -5, 5, -4, VALID_COUNT));
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, VALID_COUNT));
      // two vertices shared, point on the remaining segment
      send_query(make_query(1, 1, 1, 1, 7, 3, 4, 2, VALID_COUNT));
      // vertex counts other than three, geometry that would be inside
      send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, 15));
      send_query(make_query(0, 0, 10, 0, 0, 10, 2, 2, 0));
      send_query(make_query(0, 0, 10, 0, 0, 10, 2, 2, 2));
      send_query(make_query(0, 0, 10, 0, 0, 10, 2, 2, 4));
      wait_verdicts_drained();
   endtask

   task automatic test_random_mix(int count);
      repeat (count) send_query(random_query());
      wait_verdicts_drained();
   endtask

   // receiver holds off long enough that the pipeline fills and req_ready drops
   // while the sender keeps offering back to back
   task automatic test_output_backpressure();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      hold_cycles = 40;
      repeat (20) send_query(random_query());
      wait_verdicts_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();

      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      test_random_mix(400);

      test_output_backpressure();

      // stalls on one side at a time
      src_gaps    = 1'b0;
      sink_stalls = 1'b1;
      test_random_mix(200);
      src_gaps    = 1'b1;
      sink_stalls = 1'b0;
      test_random_mix(200);

      // closing stretch at full rate, no idling anywhere
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      test_random_mix(150);

      // anything arriving now has no expectation and gets flagged
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
